@@ hdl/mrp_pkg.sv @@
// shared constants and types for the meter record parser
`default_nettype none

package mrp_pkg;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_CHECKSUM_MODE = '0;

  // parameter defaults
  localparam int MAX_RECORD_BYTES_DEF = 30;
  localparam int MAX_VALUE_DIGITS_DEF = 12;

  // field widths
  localparam int BYTE_W   = 8;
  localparam int CLASS_W  = 4;
  localparam int NUMBER_W = 40;
  localparam int TEXT_W   = 64;
  localparam int COUNT_W  = 4;
  localparam int PEAK_W   = 10;
  localparam int SUM_W    = 6;
  localparam int HEAD_W   = 32;

  // characters
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] SUM_OFFSET = 8'h20;
  localparam logic [7:0] DIGIT_ZERO = 8'd48;
  localparam logic [7:0] DIGIT_NINE = 8'd57;
  localparam logic [PEAK_W-1:0] PEAK_LIMIT = 10'd999;

  // label classes
  localparam logic [CLASS_W-1:0] LBL_INVALID  = 4'd0;
  localparam logic [CLASS_W-1:0] LBL_ADCO     = 4'd1;
  localparam logic [CLASS_W-1:0] LBL_IINST    = 4'd2;
  localparam logic [CLASS_W-1:0] LBL_IMAX     = 4'd3;
  localparam logic [CLASS_W-1:0] LBL_ISOUSC   = 4'd4;
  localparam logic [CLASS_W-1:0] LBL_OPTARIF  = 4'd5;
  localparam logic [CLASS_W-1:0] LBL_HCHC     = 4'd6;
  localparam logic [CLASS_W-1:0] LBL_HCHP     = 4'd7;
  localparam logic [CLASS_W-1:0] LBL_HHPHC    = 4'd8;
  localparam logic [CLASS_W-1:0] LBL_PTEC     = 4'd9;
  localparam logic [CLASS_W-1:0] LBL_PAPP     = 4'd10;
  localparam logic [CLASS_W-1:0] LBL_MOTDETAT = 4'd11;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_LABEL = 5'b00010,
    PH_VALUE = 5'b00100,
    PH_GAP   = 5'b01000,
    PH_CHECK = 5'b10000
  } phase_t;

  // input register contents handed to the record logic
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } byte_stage_t;

endpackage

`default_nettype wire

@@ hdl/mrp_ifs.sv @@
// byte and record channel interfaces
`default_nettype none

interface mrp_byte_if;
  logic                       valid;
  logic                       ready;
  logic [mrp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mrp_record_if;
  logic                         valid;
  logic                         ready;
  logic [mrp_pkg::CLASS_W-1:0]  label_class;
  logic                         checksum_ok;
  logic                         malformed;
  logic [mrp_pkg::NUMBER_W-1:0] value_number;
  logic                         value_numeric;
  logic [mrp_pkg::TEXT_W-1:0]   value_text;
  logic [mrp_pkg::COUNT_W-1:0]  value_count;
  logic [mrp_pkg::PEAK_W-1:0]   current_peak;

  modport source (output valid, output label_class, output checksum_ok, output malformed,
                  output value_number, output value_numeric, output value_text,
                  output value_count, output current_peak, input ready);
  modport sink   (input valid, input label_class, input checksum_ok, input malformed,
                  input value_number, input value_numeric, input value_text,
                  input value_count, input current_peak, output ready);
endinterface

`default_nettype wire

@@ hdl/mrp_cfg_regs.sv @@
// apb configuration register: checksum mode
`default_nettype none

module mrp_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mrp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mrp_pkg::DATA_W-1:0] pwdata,
  output logic      [mrp_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output logic                            checksum_mode
);

  logic [mrp_pkg::ADDR_W-3:0] reg_index;
  logic                       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[mrp_pkg::ADDR_W-1:2];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_mode <= 1'b0;
    end else if (wr_en && (reg_index == mrp_pkg::REG_CHECKSUM_MODE)) begin
      checksum_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == mrp_pkg::REG_CHECKSUM_MODE) begin
      prdata[0] = checksum_mode;
    end
  end

endmodule

`default_nettype wire

@@ hdl/mrp_byte_stage.sv @@
// input register for received bytes
`default_nettype none

module mrp_byte_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  mrp_byte_if.sink                  bytes,
  input  wire logic                 advance,
  output mrp_pkg::byte_stage_t      stage
);

  logic                       held;
  logic [mrp_pkg::BYTE_W-1:0] data;

  // empty or draining this cycle
  assign bytes.ready = !held || advance;
  assign stage.valid = held;
  assign stage.data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (bytes.ready) begin
      held <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      data <= bytes.rx_byte;
    end
  end

endmodule

`default_nettype wire

@@ hdl/mrp_record_fsm.sv @@
// record state, checksum and result register
`default_nettype none

module mrp_record_fsm #(
  parameter int MAX_RECORD_BYTES = mrp_pkg::MAX_RECORD_BYTES_DEF,
  parameter int MAX_VALUE_DIGITS = mrp_pkg::MAX_VALUE_DIGITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 checksum_mode,
  input  wire mrp_pkg::byte_stage_t stage,
  output logic                      advance,
  mrp_record_if.source              records
);

  localparam int RL_W = $clog2(MAX_RECORD_BYTES + 1);
  localparam logic [RL_W-1:0] RL_MAX = RL_W'(MAX_RECORD_BYTES);
  localparam logic [mrp_pkg::COUNT_W-1:0] VL_MAX = mrp_pkg::COUNT_W'(MAX_VALUE_DIGITS);

  mrp_pkg::phase_t                phase, phase_next;
  logic [mrp_pkg::SUM_W-1:0]      running_sum, running_sum_next;
  logic [mrp_pkg::HEAD_W-1:0]     label_head, label_head_next;
  logic [3:0]                     label_count, label_count_next;
  logic [mrp_pkg::NUMBER_W-1:0]   value_accum, value_accum_next;
  logic [mrp_pkg::TEXT_W-1:0]     value_chars, value_chars_next;
  logic [mrp_pkg::COUNT_W-1:0]    value_len, value_len_next;
  logic                           digits_only, digits_only_next;
  logic [7:0]                     check_char, check_char_next;
  logic [RL_W-1:0]                record_len, record_len_next;
  logic                           bad_record, bad_record_next;
  logic [mrp_pkg::PEAK_W-1:0]     peak_current, peak_current_next;

  logic [7:0]                     b;
  logic                           is_cr;
  logic                           emit;
  logic                           res_ok, res_bad, res_numeric;
  logic [mrp_pkg::CLASS_W-1:0]    res_class;
  logic [mrp_pkg::NUMBER_W-1:0]   res_number;
  logic [mrp_pkg::PEAK_W-1:0]     cur;
  mrp_pkg::phase_t                ph;

  function automatic logic [mrp_pkg::CLASS_W-1:0] classify(
    input logic [mrp_pkg::HEAD_W-1:0] head
  );
    logic [7:0] c0, c1, c3;
    logic [mrp_pkg::CLASS_W-1:0] cls;
    c0  = head[7:0];
    c1  = head[15:8];
    c3  = head[31:24];
    cls = mrp_pkg::LBL_INVALID;
    case (c0)
      "A": cls = mrp_pkg::LBL_ADCO;
      "I": begin
        if (c1 == "I") cls = mrp_pkg::LBL_IINST;
        else if (c1 == "M") cls = mrp_pkg::LBL_IMAX;
        else if (c1 == "S") cls = mrp_pkg::LBL_ISOUSC;
      end
      "O": cls = mrp_pkg::LBL_OPTARIF;
      "H": begin
        if (c3 == "C") cls = mrp_pkg::LBL_HCHC;
        else if (c3 == "P") cls = mrp_pkg::LBL_HCHP;
        else if (c3 == "H") cls = mrp_pkg::LBL_HHPHC;
      end
      "P": begin
        if (c1 == "T") cls = mrp_pkg::LBL_PTEC;
        else if (c1 == "A") cls = mrp_pkg::LBL_PAPP;
      end
      "M": cls = mrp_pkg::LBL_MOTDETAT;
      default: cls = mrp_pkg::LBL_INVALID;
    endcase
    return cls;
  endfunction

  assign b     = stage.data;
  assign is_cr = (b == mrp_pkg::CH_CR);
  // a record result needs the output register free
  assign advance = stage.valid && (!is_cr || !records.valid || records.ready);
  assign emit    = advance && is_cr;

  // record close
  always_comb begin
    res_bad = bad_record;
    if ((phase != mrp_pkg::PH_CHECK) || (label_count == '0) || (value_len == '0)) begin
      res_bad = 1'b1;
    end
    if (record_len >= RL_MAX) begin
      res_bad = 1'b1;
    end
    res_ok      = (phase == mrp_pkg::PH_CHECK) &&
                  (check_char == ({2'b00, running_sum} + mrp_pkg::SUM_OFFSET));
    res_class   = classify(label_head);
    res_numeric = (value_len != '0) && digits_only;
    res_number  = res_numeric ? value_accum : '0;
    cur = (res_number > mrp_pkg::NUMBER_W'(mrp_pkg::PEAK_LIMIT)) ?
          mrp_pkg::PEAK_LIMIT : res_number[mrp_pkg::PEAK_W-1:0];
    peak_current_next = peak_current;
    if ((res_class == mrp_pkg::LBL_IINST) && res_ok && !res_bad && res_numeric &&
        (cur > peak_current)) begin
      peak_current_next = cur;
    end
  end

  // per-byte record update
  always_comb begin
    phase_next       = phase;
    running_sum_next = running_sum;
    label_head_next  = label_head;
    label_count_next = label_count;
    value_accum_next = value_accum;
    value_chars_next = value_chars;
    value_len_next   = value_len;
    digits_only_next = digits_only;
    check_char_next  = check_char;
    record_len_next  = record_len;
    bad_record_next  = bad_record;
    ph               = phase;

    if ((b == mrp_pkg::CH_STX) || (b == mrp_pkg::CH_ETX)) begin
      // framing bytes leave the record untouched
    end else if ((b == mrp_pkg::CH_LF) || is_cr) begin
      phase_next       = is_cr ? mrp_pkg::PH_IDLE : mrp_pkg::PH_LABEL;
      running_sum_next = '0;
      label_head_next  = '0;
      label_count_next = '0;
      value_accum_next = '0;
      value_chars_next = '0;
      value_len_next   = '0;
      digits_only_next = 1'b1;
      check_char_next  = '0;
      record_len_next  = is_cr ? '0 : RL_W'(1);
      bad_record_next  = 1'b0;
    end else begin
      // no leading line feed: start a flagged record
      if (phase == mrp_pkg::PH_IDLE) begin
        ph              = mrp_pkg::PH_LABEL;
        bad_record_next = 1'b1;
      end
      phase_next = ph;
      if (record_len < RL_MAX) begin
        record_len_next = record_len + RL_W'(1);
      end else begin
        bad_record_next = 1'b1;
      end
      unique case (ph)
        mrp_pkg::PH_LABEL: begin
          running_sum_next = running_sum + b[mrp_pkg::SUM_W-1:0];
          if (b == mrp_pkg::CH_SP) begin
            phase_next = mrp_pkg::PH_VALUE;
          end else begin
            if (label_count < 4'd4) begin
              label_head_next[8*label_count[1:0] +: 8] = b;
            end
            if (label_count != 4'd15) begin
              label_count_next = label_count + 4'd1;
            end
          end
        end
        mrp_pkg::PH_VALUE: begin
          if (b == mrp_pkg::CH_SP) begin
            if (checksum_mode) begin
              running_sum_next = running_sum + b[mrp_pkg::SUM_W-1:0];
            end
            phase_next = mrp_pkg::PH_GAP;
          end else begin
            running_sum_next = running_sum + b[mrp_pkg::SUM_W-1:0];
            if (value_len >= VL_MAX) begin
              bad_record_next = 1'b1;
            end else begin
              if ((b >= mrp_pkg::DIGIT_ZERO) && (b <= mrp_pkg::DIGIT_NINE)) begin
                value_accum_next = (value_accum << 3) + (value_accum << 1) +
                                   mrp_pkg::NUMBER_W'(b - mrp_pkg::DIGIT_ZERO);
              end else begin
                digits_only_next = 1'b0;
              end
              if (value_len < 4'd8) begin
                value_chars_next[8*value_len[2:0] +: 8] = b;
              end
              value_len_next = value_len + 4'd1;
            end
          end
        end
        mrp_pkg::PH_GAP, mrp_pkg::PH_CHECK: begin
          check_char_next = b;
          phase_next      = mrp_pkg::PH_CHECK;
        end
        default: begin
          phase_next = mrp_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= mrp_pkg::PH_IDLE;
      running_sum  <= '0;
      label_head   <= '0;
      label_count  <= '0;
      value_accum  <= '0;
      value_chars  <= '0;
      value_len    <= '0;
      digits_only  <= 1'b1;
      check_char   <= '0;
      record_len   <= '0;
      bad_record   <= 1'b0;
      peak_current <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      running_sum  <= running_sum_next;
      label_head   <= label_head_next;
      label_count  <= label_count_next;
      value_accum  <= value_accum_next;
      value_chars  <= value_chars_next;
      value_len    <= value_len_next;
      digits_only  <= digits_only_next;
      check_char   <= check_char_next;
      record_len   <= record_len_next;
      bad_record   <= bad_record_next;
      if (is_cr) begin
        peak_current <= peak_current_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      records.valid <= 1'b0;
    end else if (emit) begin
      records.valid <= 1'b1;
    end else if (records.ready) begin
      records.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      records.label_class   <= res_class;
      records.checksum_ok   <= res_ok;
      records.malformed     <= res_bad;
      records.value_number  <= res_number;
      records.value_numeric <= res_numeric;
      records.value_text    <= value_chars;
      records.value_count   <= value_len;
      records.current_peak  <= peak_current_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/meter_record_parser.sv @@
// meter record parser top level
//
// bytes: one received character per request (valid/ready); STX and ETX are
//   dropped, LF opens a record, CR closes it and yields exactly one request
//   on records carrying label class, checksum verdict, malformed flag, the
//   value as number and text, its length and the peak instantaneous current.
// apb: register 0 bit 0 selects whether the second space enters the sum;
//   write it only while no byte is in flight.
// order: a byte is held in the input register; its record update is
//   registered in the state registers, and a CR's result in the result
//   register, when the byte leaves the input register.
// throughput: one byte per cycle while no CR waits for the output register;
//   the update is combinational between input, state and result registers.
// stall: a waiting result holds the output register; bytes other than CR
//   keep flowing, a CR waits in the input register until the result is taken.
// reset: clears the record state, the checksum mode and the current peak.
`default_nettype none

module meter_record_parser #(
  parameter int MAX_RECORD_BYTES = mrp_pkg::MAX_RECORD_BYTES_DEF,
  parameter int MAX_VALUE_DIGITS = mrp_pkg::MAX_VALUE_DIGITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  mrp_byte_if.sink                        bytes,
  mrp_record_if.source                    records,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mrp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mrp_pkg::DATA_W-1:0] pwdata,
  output logic      [mrp_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);

  logic                 checksum_mode;
  logic                 advance;
  mrp_pkg::byte_stage_t stage;

  mrp_cfg_regs u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .checksum_mode (checksum_mode)
  );

  mrp_byte_stage u_stage (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes),
    .advance (advance),
    .stage   (stage)
  );

  mrp_record_fsm #(
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES),
    .MAX_VALUE_DIGITS (MAX_VALUE_DIGITS)
  ) u_fsm (
    .clk           (clk),
    .rst           (rst),
    .checksum_mode (checksum_mode),
    .stage         (stage),
    .advance       (advance),
    .records       (records)
  );

  // an empty input register always takes a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !stage.valid |-> bytes.ready)
    else $error("input register empty but not ready");

  // the state only moves on a held byte
  a_advance_needs_byte: assert property (@(posedge clk) disable iff (rst)
    advance |-> stage.valid)
    else $error("record update without a byte");

  // a new result only follows a byte that was processed
  a_result_from_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(records.valid) |-> $past(advance))
    else $error("result appeared without a processed byte");

  // peak stays within the saturation limit
  a_peak_limit: assert property (@(posedge clk) disable iff (rst)
    records.valid |-> (records.current_peak <= mrp_pkg::PEAK_LIMIT))
    else $error("current peak above limit");

endmodule

`default_nettype wire
